// ===== hdl/asop_pkg.sv =====
// Shared types, codes and sizes for the adaptive server optimizer step block.
// No dependencies; asop_divsqrt and the top level import this package.
`default_nettype none

package asop_pkg;

    // Element store size; the index field itself is fixed at 12 bits.
    localparam int ELEMENTS = 4096;
    localparam int ADDR_W   = $clog2(ELEMENTS);
    localparam int IDX_W    = 12;

    // Operation codes carried on the input tuser
    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_ACCUM = 2'd1;
    localparam logic [1:0] OP_APPLY = 2'd2;

    // Second moment rules; the unused code behaves as Adam
    localparam logic [1:0] MODE_ADAGRAD = 2'd0;
    localparam logic [1:0] MODE_ADAM    = 2'd1;
    localparam logic [1:0] MODE_YOGI    = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_MODE = 3'd0;
    localparam logic [2:0] REG_B1   = 3'd1;
    localparam logic [2:0] REG_B2   = 3'd2;
    localparam logic [2:0] REG_TAU  = 3'd3;
    localparam logic [2:0] REG_LR   = 3'd4;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    // Iterative unit step counts
    localparam int DIV_STEPS  = 64;
    localparam int SQRT_STEPS = 24;
    localparam int CNT_W      = $clog2(DIV_STEPS + 1);

    // One memory word per element
    typedef struct packed {
        logic signed [31:0] acc;
        logic signed [31:0] fm;
        logic        [31:0] sm;
    } entry_t;

    typedef struct packed {
        logic start;
        logic is_sqrt;
    } dsu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dsu_stat_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_LOAD,
        ST_ACC_MUL, ST_ACC_WR,
        ST_BR_MUL1, ST_BR_MUL2, ST_BR_UPD,
        ST_AP_M1, ST_AP_M2, ST_AP_S1, ST_AP_S2, ST_AP_S3,
        ST_AP_K1, ST_AP_K2, ST_AP_K3, ST_AP_V, ST_AP_W,
        ST_DIV1, ST_DIV1_W, ST_DIV2, ST_DIV2_W, ST_SQRT, ST_SQRT_W,
        ST_FIN_M1, ST_FIN_M2, ST_FIN_M3, ST_FIN_W, ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ===== hdl/asop_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module asop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/asop_divsqrt.sv =====
// Shared iterative unit: 64-bit by 32-bit restoring divide, one quotient bit a cycle,
// or 48-bit floor square root, one root bit a cycle. Depends on asop_pkg.
`default_nettype none

module asop_divsqrt (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire asop_pkg::dsu_req_t  req,
    input  wire logic [63:0]         num,
    input  wire logic [31:0]         den,
    output asop_pkg::dsu_stat_t      stat,
    output logic [63:0]              quot
);
    import asop_pkg::*;

    logic [63:0]      work_reg, work_next;
    logic [63:0]      quot_reg, quot_next;
    logic [32:0]      rem_reg, rem_next;
    logic [31:0]      den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             sqrt_reg, sqrt_next;

    logic [32:0] rem_sh;
    logic [32:0] trial;
    logic        ge;

    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[30:0], work_reg[63:62]};
            trial  = {7'b0, quot_reg[23:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[31:0], work_reg[63]};
            trial  = {1'b0, den_reg};
        end
        ge = (rem_sh >= trial);
    end

    always_comb begin
        work_next = work_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        sqrt_next = sqrt_reg;
        if (req.start) begin
            work_next = num;
            den_next  = den;
            quot_next = '0;
            rem_next  = '0;
            sqrt_next = req.is_sqrt;
            cnt_next  = req.is_sqrt ? CNT_W'(SQRT_STEPS) : CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            quot_next = {quot_reg[62:0], ge};
            work_next = sqrt_reg ? {work_reg[61:0], 2'b00} : {work_reg[62:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        work_reg <= work_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        sqrt_reg <= sqrt_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

`default_nettype wire

// ===== hdl/adaptive_server_optimizer_step.sv =====
// Top level of the per-element server optimizer (Adagrad, Adam, Yogi) in Q16.16.
// Depends on asop_pkg, asop_ram and asop_divsqrt.
//
//  Channel   Dir  Handshake           Payload
//  s_*       in   s_tvalid/s_tready   tdata: index, delta, weight; tuser: operation
//  m_*       out  m_tvalid/m_tready   tdata: index, update value; tuser: saturated
//  cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (always ready)
//
// One item at a time. Begin-round beats pass through load, two multiplies and an update;
// accumulate beats through load, a multiply and a write-back. Apply uses up to three
// divides and a root in Adam and Yogi mode, one divide and a root in Adagrad mode, on the
// shared divide/square-root unit (64 steps per divide, 24 per root). A clearing pass
// after reset zeroes all ELEMENTS (4096) entries; s_tready stays low throughout. A result
// held on a stalled m_* side does not block new input; only the next apply waits for it.
`default_nettype none

module adaptive_server_optimizer_step (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // [11:0] element_index, [43:12] delta_value,
                                        // [60:44] client_weight, [63:61] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] operation
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [47:0] m_tdata,   // [11:0] out_index, [43:12] update value,
                                        // [47:44] zero
    output logic             m_tuser,   // [0] saturated
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import asop_pkg::*;

    // Configuration
    logic [1:0]  mode_reg;
    logic [15:0] b1_reg, b2_reg;
    logic [30:0] tau_reg, lr_reg;

    // Round state
    logic [16:0] bfp_reg, bfp_next, bsp_reg, bsp_next;

    state_t state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;

    // Accepted beat
    logic [1:0]         op_reg, op_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic signed [31:0] delta_reg, delta_next;
    logic [16:0]        w_reg, w_next;

    // Entry read back
    logic signed [31:0] d_reg, d_next, m_reg, m_next;
    logic [31:0]        v_reg, v_next;

    // Shared multiplier, registered product
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] prod_reg;

    // Working registers
    logic signed [50:0] sum_reg, sum_next;
    logic signed [31:0] mn_reg, mn_next;
    logic [47:0]        sq_reg, sq_next;
    logic [46:0]        s_reg, s_next;
    logic [63:0]        sk_reg, sk_next;
    logic [63:0]        nvw_reg, nvw_next;
    logic [31:0]        nv_reg, nv_next;
    logic [31:0]        amh_reg, amh_next;
    logic               neg_reg, neg_next;
    logic [31:0]        vh_reg, vh_next;
    logic [31:0]        den_reg, den_next;
    logic [47:0]        fp_reg, fp_next;
    logic signed [31:0] res_reg, res_next;
    logic               sat_reg, sat_next;

    // Output register
    logic               ov_reg, ov_next;
    logic [IDX_W-1:0]   oidx_reg, oidx_next;
    logic signed [31:0] odelta_reg, odelta_next;
    logic               osat_reg, osat_next;

    // Memory port
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    entry_t            mem_wdata, mem_rdata;

    // Iterative unit
    dsu_req_t    dsu_req;
    dsu_stat_t   dsu_stat;
    logic [63:0] dsu_num, dsu_quot;
    logic [31:0] dsu_den;

    // Helpers
    logic [31:0]        ad;
    logic [31:0]        amn;
    logic [16:0]        c1, c2;
    logic signed [51:0] prod_sx, sum_sx, d_sx, msum, mq, asum;
    logic [63:0]        v64, s64, t64, vb64;
    logic [31:0]        den_sum;
    logic               in_range;
    logic               s_fire;

    assign s_fire    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign in_range  = ({20'b0, s_tdata[11:0]} < 32'(ELEMENTS));

    assign ad       = d_reg[31] ? (~d_reg + 32'd1) : d_reg;
    assign amn      = mn_reg[31] ? (~mn_reg + 32'd1) : mn_reg;
    assign c1       = bfp_reg[16] ? 17'd0 : (17'd65536 - bfp_reg);
    assign c2       = bsp_reg[16] ? 17'd0 : (17'd65536 - bsp_reg);
    assign prod_sx  = {prod_reg[50], prod_reg};
    assign sum_sx   = {sum_reg[50], sum_reg};
    assign d_sx     = {{20{d_reg[31]}}, d_reg};
    assign msum     = sum_sx + prod_sx;
    assign mq       = msum >>> 16;
    assign asum     = d_sx + (prod_sx >>> 16);
    assign v64      = {32'b0, v_reg};
    assign s64      = {17'b0, s_reg};
    assign t64      = {16'b0, sk_reg[63:16]};
    assign vb64     = {16'b0, prod_reg[47:0]};
    assign den_sum  = {8'b0, dsu_quot[23:0]} + {1'b0, tau_reg};

    // Signed 32-bit saturation of a wide value: {flag, value}
    function automatic logic [32:0] clamp_s32(input logic signed [51:0] x);
        logic [32:0] r;
        if (!x[51] && (|x[50:31])) begin
            r = {1'b1, S32_MAX};
        end else if (x[51] && !(&x[50:31])) begin
            r = {1'b1, S32_MIN};
        end else begin
            r = {1'b0, x[31:0]};
        end
        return r;
    endfunction

    // sign * magnitude with saturation: {flag, value}
    function automatic logic [32:0] signed_clamp(input logic neg, input logic [63:0] q);
        logic [32:0] r;
        if (neg) begin
            if ((|q[63:32]) || (q[31] && (|q[30:0]))) begin
                r = {1'b1, S32_MIN};
            end else begin
                r = {1'b0, ~q[31:0] + 32'd1};
            end
        end else begin
            if (|q[63:31]) begin
                r = {1'b1, S32_MAX};
            end else begin
                r = {1'b0, q[31:0]};
            end
        end
        return r;
    endfunction

    // Multiplier operand selection
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_BR_MUL1: begin mul_a = {16'b0, bfp_reg};      mul_b = {2'b0, b1_reg}; end
            ST_BR_MUL2: begin mul_a = {16'b0, bsp_reg};      mul_b = {2'b0, b2_reg}; end
            ST_ACC_MUL: begin mul_a = {delta_reg[31], delta_reg}; mul_b = {1'b0, w_reg}; end
            ST_AP_M1:   begin mul_a = {m_reg[31], m_reg};    mul_b = {2'b0, b1_reg}; end
            ST_AP_M2:   begin
                mul_a = {d_reg[31], d_reg};
                mul_b = {1'b0, 17'd65536 - {1'b0, b1_reg}};
            end
            ST_AP_S1:   begin mul_a = {1'b0, ad};            mul_b = {2'b0, ad[15:0]}; end
            ST_AP_S2:   begin mul_a = {1'b0, ad};            mul_b = {2'b0, ad[31:16]}; end
            ST_AP_K1:   begin
                mul_a = {1'b0, s_reg[31:0]};
                mul_b = {1'b0, 17'd65536 - {1'b0, b2_reg}};
            end
            ST_AP_K2:   begin
                mul_a = {18'b0, s_reg[46:32]};
                mul_b = {1'b0, 17'd65536 - {1'b0, b2_reg}};
            end
            ST_AP_K3:   begin mul_a = {1'b0, v_reg};         mul_b = {2'b0, b2_reg}; end
            ST_FIN_M1:  begin mul_a = {1'b0, amh_reg};       mul_b = {2'b0, lr_reg[15:0]}; end
            ST_FIN_M2:  begin mul_a = {1'b0, amh_reg};       mul_b = {3'b0, lr_reg[30:16]}; end
            default:    begin mul_a = '0;                    mul_b = '0; end
        endcase
    end

    // Sequencer: next state, working registers, memory and unit control
    always_comb begin
        logic [32:0] cl;
        cl          = '0;
        state_next  = state_reg;
        clr_next    = clr_reg;
        bfp_next    = bfp_reg;
        bsp_next    = bsp_reg;
        op_next     = op_reg;
        idx_next    = idx_reg;
        delta_next  = delta_reg;
        w_next      = w_reg;
        d_next      = d_reg;
        m_next      = m_reg;
        v_next      = v_reg;
        sum_next    = sum_reg;
        mn_next     = mn_reg;
        sq_next     = sq_reg;
        s_next      = s_reg;
        sk_next     = sk_reg;
        nvw_next    = nvw_reg;
        nv_next     = nv_reg;
        amh_next    = amh_reg;
        neg_next    = neg_reg;
        vh_next     = vh_reg;
        den_next    = den_reg;
        fp_next     = fp_reg;
        res_next    = res_reg;
        sat_next    = sat_reg;
        ov_next     = ov_reg && !m_tready;
        oidx_next   = oidx_reg;
        odelta_next = odelta_reg;
        osat_next   = osat_reg;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(idx_reg);
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = ADDR_W'(s_tdata[11:0]);
        dsu_req     = '0;
        dsu_num     = '0;
        dsu_den     = '0;

        case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(ELEMENTS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_fire) begin
                    op_next    = (s_tuser == OP_BEGIN || in_range) ? s_tuser : 2'd3;
                    idx_next   = s_tdata[11:0];
                    delta_next = s_tdata[43:12];
                    w_next     = s_tdata[60:44];
                    sat_next   = 1'b0;
                    mem_re     = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                d_next = mem_rdata.acc;
                m_next = mem_rdata.fm;
                v_next = mem_rdata.sm;
                case (op_reg)
                    OP_BEGIN: state_next = ST_BR_MUL1;
                    OP_ACCUM: state_next = ST_ACC_MUL;
                    OP_APPLY: state_next = ST_AP_M1;
                    default:  state_next = ST_IDLE;
                endcase
            end
            ST_BR_MUL1: state_next = ST_BR_MUL2;
            ST_BR_MUL2: begin
                bfp_next   = prod_reg[32:16];
                state_next = ST_BR_UPD;
            end
            ST_BR_UPD: begin
                bsp_next   = prod_reg[32:16];
                state_next = ST_IDLE;
            end
            ST_ACC_MUL: state_next = ST_ACC_WR;
            ST_ACC_WR: begin
                cl            = clamp_s32(asum);
                mem_we        = 1'b1;
                mem_wdata.acc = cl[31:0];
                mem_wdata.fm  = m_reg;
                mem_wdata.sm  = v_reg;
                state_next    = ST_IDLE;
            end
            ST_AP_M1: state_next = ST_AP_M2;
            ST_AP_M2: begin
                sum_next   = prod_reg;
                state_next = ST_AP_S1;
            end
            ST_AP_S1: begin
                cl         = clamp_s32(mq);
                mn_next    = cl[31:0];
                sat_next   = sat_reg || cl[32];
                state_next = ST_AP_S2;
            end
            ST_AP_S2: begin
                sq_next    = prod_reg[47:0];
                state_next = ST_AP_S3;
            end
            ST_AP_S3: begin
                s_next     = {15'b0, sq_reg[47:16]} + prod_reg[46:0];
                state_next = ST_AP_K1;
            end
            ST_AP_K1: state_next = ST_AP_K2;
            ST_AP_K2: begin
                sk_next    = {15'b0, prod_reg[48:0]};
                state_next = ST_AP_K3;
            end
            ST_AP_K3: begin
                sk_next    = sk_reg + {prod_reg[31:0], 32'b0};
                state_next = ST_AP_V;
            end
            ST_AP_V: begin
                case (mode_reg)
                    MODE_ADAGRAD: nvw_next = v64 + s64;
                    MODE_YOGI: begin
                        if (v64 > s64) begin
                            nvw_next = v64 - t64;
                        end else if (v64 < s64) begin
                            nvw_next = v64 + t64;
                        end else begin
                            nvw_next = v64;
                        end
                    end
                    default: nvw_next = (vb64 + sk_reg) >> 16;
                endcase
                state_next = ST_AP_W;
            end
            ST_AP_W: begin
                // Clamp, store both moments and clear the accumulator entry
                if (|nvw_reg[63:32]) begin
                    nv_next  = 32'hFFFF_FFFF;
                    sat_next = 1'b1;
                end else begin
                    nv_next  = nvw_reg[31:0];
                end
                mem_we       = 1'b1;
                mem_wdata.fm = mn_reg;
                mem_wdata.sm = (|nvw_reg[63:32]) ? 32'hFFFF_FFFF : nvw_reg[31:0];
                amh_next     = amn;
                neg_next     = mn_reg[31];
                if (mode_reg == MODE_ADAGRAD) begin
                    vh_next    = (|nvw_reg[63:32]) ? 32'hFFFF_FFFF : nvw_reg[31:0];
                    state_next = ST_SQRT;
                end else if (c1 == 17'd0 || c2 == 17'd0) begin
                    res_next   = (mn_reg == 32'sd0) ? 32'sd0 : (mn_reg[31] ? S32_MIN : S32_MAX);
                    sat_next   = 1'b1;
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_DIV1;
                end
            end
            ST_DIV1: begin
                dsu_req.start = 1'b1;
                dsu_num       = {16'b0, amh_reg, 16'b0};
                dsu_den       = {15'b0, c1};
                state_next    = ST_DIV1_W;
            end
            ST_DIV1_W: begin
                if (dsu_stat.done) begin
                    cl         = signed_clamp(neg_reg, dsu_quot);
                    amh_next   = neg_reg ? (~cl[31:0] + 32'd1) : cl[31:0];
                    sat_next   = sat_reg || cl[32];
                    state_next = ST_DIV2;
                end
            end
            ST_DIV2: begin
                dsu_req.start = 1'b1;
                dsu_num       = {16'b0, nv_reg, 16'b0};
                dsu_den       = {15'b0, c2};
                state_next    = ST_DIV2_W;
            end
            ST_DIV2_W: begin
                if (dsu_stat.done) begin
                    if (|dsu_quot[63:32]) begin
                        vh_next  = 32'hFFFF_FFFF;
                        sat_next = 1'b1;
                    end else begin
                        vh_next  = dsu_quot[31:0];
                    end
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                dsu_req.start   = 1'b1;
                dsu_req.is_sqrt = 1'b1;
                dsu_num         = {vh_reg, 32'b0};
                state_next      = ST_SQRT_W;
            end
            ST_SQRT_W: begin
                if (dsu_stat.done) begin
                    den_next = den_sum;
                    if (den_sum == 32'd0) begin
                        res_next   = (amh_reg == 32'd0) ? 32'sd0 :
                                     (neg_reg ? S32_MIN : S32_MAX);
                        sat_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_FIN_M1;
                    end
                end
            end
            ST_FIN_M1: state_next = ST_FIN_M2;
            ST_FIN_M2: begin
                fp_next    = prod_reg[47:0];
                state_next = ST_FIN_M3;
            end
            ST_FIN_M3: begin
                dsu_req.start = 1'b1;
                dsu_num       = {16'b0, fp_reg} + {1'b0, prod_reg[46:0], 16'b0};
                dsu_den       = den_reg;
                state_next    = ST_FIN_W;
            end
            ST_FIN_W: begin
                if (dsu_stat.done) begin
                    cl         = signed_clamp(neg_reg, dsu_quot);
                    res_next   = cl[31:0];
                    sat_next   = sat_reg || cl[32];
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                // Hold until the output register is free
                if (!ov_reg || m_tready) begin
                    ov_next     = 1'b1;
                    oidx_next   = idx_reg;
                    odelta_next = res_reg;
                    osat_next   = sat_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            ov_reg    <= 1'b0;
            bfp_reg   <= 17'd65536;
            bsp_reg   <= 17'd65536;
            mode_reg  <= MODE_ADAM;
            b1_reg    <= 16'd58982;
            b2_reg    <= 16'd64881;
            tau_reg   <= 31'd66;
            lr_reg    <= 31'd65536;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ov_reg    <= ov_next;
            bfp_reg   <= bfp_next;
            bsp_reg   <= bsp_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_B1:   b1_reg   <= cfg_data[15:0];
                    REG_B2:   b2_reg   <= cfg_data[15:0];
                    REG_TAU:  tau_reg  <= cfg_data[30:0];
                    REG_LR:   lr_reg   <= cfg_data[30:0];
                    default:  ;
                endcase
            end
        end
        prod_reg   <= mul_a * mul_b;
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        delta_reg  <= delta_next;
        w_reg      <= w_next;
        d_reg      <= d_next;
        m_reg      <= m_next;
        v_reg      <= v_next;
        sum_reg    <= sum_next;
        mn_reg     <= mn_next;
        sq_reg     <= sq_next;
        s_reg      <= s_next;
        sk_reg     <= sk_next;
        nvw_reg    <= nvw_next;
        nv_reg     <= nv_next;
        amh_reg    <= amh_next;
        neg_reg    <= neg_next;
        vh_reg     <= vh_next;
        den_reg    <= den_next;
        fp_reg     <= fp_next;
        res_reg    <= res_next;
        sat_reg    <= sat_next;
        oidx_reg   <= oidx_next;
        odelta_reg <= odelta_next;
        osat_reg   <= osat_next;
    end

    // Element store: accumulator, first and second moment in one word
    asop_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (ELEMENTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Divides and square root share one unit
    asop_divsqrt u_dsu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dsu_req),
        .num     (dsu_num),
        .den     (dsu_den),
        .stat    (dsu_stat),
        .quot    (dsu_quot)
    );

    assign m_tvalid = ov_reg;
    assign m_tdata  = {4'b0, odelta_reg, oidx_reg};
    assign m_tuser  = osat_reg;

endmodule

`default_nettype wire

// ===== hdl/asop_checker.sv =====
// Port-level checks for adaptive_server_optimizer_step, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module asop_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [47:0] m_tdata,
    input wire logic        m_tuser
);

    // Clearing pass follows reset: no beat taken straight after it
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(aresetn) |-> !s_tready)
        else $error("input ready straight after reset");

    // One item at a time
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready in the cycle after a beat");

    // A result never appears in the cycle straight after an input beat
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
        else $error("result raised directly after an input beat");

    // Stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result beat changed");

endmodule

bind adaptive_server_optimizer_step asop_checker u_asop_checker (.*);

`default_nettype wire
